[rtl/inc_pkg.sv]
// Package for the neighbor compensation block: request codes, state encoding,
// controller/datapath command and status structs. No dependencies.
package inc_pkg;

    // store depth, tied to the 16-bit pixel index
    localparam int MAX_PIXELS = 65536;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_PASS = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_READ_WAIT,
        ST_PIX_START,
        ST_WIN_ISSUE,
        ST_WIN_DRAIN,
        ST_ORIG_WAIT,
        ST_WRITE,
        ST_NEXT,
        ST_DONE
    } t_state;

    localparam int unsigned LUM_R = 13933;
    localparam int unsigned LUM_G = 46871;
    localparam int unsigned LUM_B = 4732;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;    // write original and luminance
        logic rd_canvas;  // read canvas at the request index
        logic pass_init;  // capture frame limits and window size, clear y/x
        logic pix_init;   // clear window counters and sums
        logic win_step;   // issue one window read (or skip if clipped)
        logic orig_rd;    // read original of current pixel
        logic wr_result;  // write new canvas value
        logic pix_next;   // advance raster position
        logic cap_read;   // latch read data to result
        logic clear_res;  // zero result colour
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic win_last;   // window step issued was the final one
        logic pix_last;   // current pixel is the last of the frame
        logic frame_empty;
    } t_sts;

endpackage

[rtl/inplace_neighbour_compensation.sv]
// Top level of the neighbor compensation block: config registers and the
// controller/datapath pair. Depends on inc_pkg, inc_ctrl, inc_datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  request | i_req_valid/o_req_stall| i_req_type i_pixel_index i_red/green/blue_in
//  result  | o_res_valid/i_res_stall| o_red/green/blue_out o_done_kind
//  config  | i_cfg_valid/o_cfg_ready| i_cfg_index i_cfg_data
//
// A pass issues every window tap, clipped taps included, on the single canvas read port.
// A new request is accepted only once the previous one has finished.
// Reset is synchronous and clears control only; the stores stay undefined.
// A result held under stall blocks the next request.
module inplace_neighbour_compensation #(
    parameter int MAX_WINDOW = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_pixel_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [1:0]  o_done_kind,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import inc_pkg::*;

    logic [8:0] r_width, r_height;
    logic [3:0] r_window;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_window <= 4'd7;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_WINDOW: r_window <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    inc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .i_req         (t_req'(i_req_type)),
        .o_req_stall   (o_req_stall),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_done_kind   (o_done_kind),
        .o_cmd         (cmd),
        .i_sts         (sts),
        .i_idx_ok      (17'(i_pixel_index) < 17'(MAX_PIXELS))
    );

    inc_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_pixel_index  (i_pixel_index),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_image_width  (r_width),
        .i_image_height (r_height),
        .i_window_size  (r_window),
        .o_red          (o_red_out),
        .o_green        (o_green_out),
        .o_blue         (o_blue_out)
    );
endmodule

[rtl/inc_datapath.sv]
// Datapath: original and canvas memories, window sweep counters, channel sums.
// Depends on inc_pkg; driven by inc_ctrl.
module inc_datapath #(
    parameter int MAX_WINDOW = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  inc_pkg::t_cmd          i_cmd,
    output inc_pkg::t_sts          o_sts,
    input  logic [15:0]            i_pixel_index,
    input  logic [7:0]             i_red_in,
    input  logic [7:0]             i_green_in,
    input  logic [7:0]             i_blue_in,
    input  logic [8:0]             i_image_width,
    input  logic [8:0]             i_image_height,
    input  logic [3:0]             i_window_size,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue
);
    import inc_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int SW = 8 + 2 * WW;  // sum width

    logic [23:0] r_orig_mem   [MAX_PIXELS];
    logic [23:0] r_canvas_mem [MAX_PIXELS];

    logic [23:0] r_canvas_q, r_orig_q;
    logic        r_canvas_vld;  // window read data lands this cycle

    logic [8:0]  r_w, r_h;
    logic [WW-1:0] r_size;
    logic [8:0]  r_x, r_y;
    logic [WW-1:0] r_wx, r_wy;   // window offsets 0..size-1
    logic [SW-1:0] r_sum [3];
    logic [WW*2-1:0] r_cnt;
    logic [7:0]  r_red, r_green, r_blue;
    logic [7:0]  n_res [3];

    // load path: luminance, index range check
    logic [25:0] lum_full;
    logic [7:0]  lum;
    logic        idx_ok;
    assign lum_full = 26'(LUM_R) * 26'(i_red_in) + 26'(LUM_G) * 26'(i_green_in)
                    + 26'(LUM_B) * 26'(i_blue_in) + 26'd32768;
    assign lum = lum_full[23:16];
    assign idx_ok = (17'(i_pixel_index) < 17'(MAX_PIXELS));

    // pass setup: saturate dims and window
    logic [8:0] w_sat, h_sat;
    logic [8:0]  h_fit;
    logic [WW-1:0] size_sat;
    assign w_sat = (i_image_width == 9'd0) ? 9'd1 :
                   (i_image_width > 9'd256) ? 9'd256 : i_image_width;
    assign h_sat = (i_image_height == 9'd0) ? 9'd1 :
                   (i_image_height > 9'd256) ? 9'd256 : i_image_height;
    assign size_sat = (32'(i_window_size) > MAX_WINDOW) ? WW'(MAX_WINDOW)
                                                         : WW'(i_window_size);

    // a saturated frame holds at most 256*256 pixels, which always fits the
    // store, so the height needs no further limit
    assign h_fit = h_sat;

    // window geometry: absolute coordinates
    logic signed [10:0] wyc, wxc;
    logic        in_frame;
    logic [15:0] lin;
    logic [WW-1:0] half;
    assign half = r_size >> 1;
    assign wyc = $signed({2'b0, r_y}) + $signed({1'b0, 10'(r_wy)}) - $signed({1'b0, 10'(half)});
    assign wxc = $signed({2'b0, r_x}) + $signed({1'b0, 10'(r_wx)}) - $signed({1'b0, 10'(half)});
    assign in_frame = (wyc >= 0) && (wyc < $signed({2'b0, r_h}))
                   && (wxc >= 0) && (wxc < $signed({2'b0, r_w}));
    assign lin = 16'(wyc[8:0] * r_w + 18'(wxc[8:0]));

    logic [15:0] cur;
    assign cur = 16'(r_y * r_w + 18'(r_x));

    logic win_last;
    assign win_last = (r_size == '0) ||
                      ((r_wx == r_size - 1'b1) && (r_wy == r_size - 1'b1));

    always_comb begin
        o_sts.win_last    = win_last;
        o_sts.pix_last    = (r_x == r_w - 9'd1) && (r_y == r_h - 9'd1);
        o_sts.frame_empty = (r_h == 9'd0);
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && idx_ok) begin
            r_orig_mem[AW'(i_pixel_index)]   <= {i_red_in, i_green_in, i_blue_in};
            r_canvas_mem[AW'(i_pixel_index)] <= {lum, lum, lum};
        end else if (i_cmd.wr_result) begin
            r_canvas_mem[AW'(cur)] <= {n_res[0], n_res[1], n_res[2]};
        end
        if (i_cmd.rd_canvas) begin
            r_canvas_q <= r_canvas_mem[AW'(i_pixel_index)];
        end else begin
            r_canvas_q <= r_canvas_mem[AW'(lin)];
        end
        r_orig_q <= r_orig_mem[AW'(cur)];
    end

    // new value per channel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [SW+10:0] v;
            v = $signed({1'b0, (SW+10)'(r_orig_q[16-8*k +: 8]) * (SW+10)'(r_cnt + 1'b1)})
              - $signed({1'b0, (SW+10)'(r_sum[k])});
            if (v < 0) n_res[k] = 8'd0;
            else if (v > 255) n_res[k] = 8'd255;
            else n_res[k] = v[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_vld <= 1'b0;
        end else begin
            r_canvas_vld <= i_cmd.win_step && in_frame && (r_size != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_init) begin
            r_w    <= w_sat;
            r_h    <= h_fit;
            r_size <= size_sat;
            r_x    <= 9'd0;
            r_y    <= 9'd0;
        end else if (i_cmd.pix_next) begin
            if (r_x == r_w - 9'd1) begin
                r_x <= 9'd0;
                r_y <= r_y + 9'd1;
            end else begin
                r_x <= r_x + 9'd1;
            end
        end
        if (i_cmd.pix_init) begin
            r_wx  <= '0;
            r_wy  <= '0;
            r_cnt <= '0;
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end else begin
            if (i_cmd.win_step) begin
                if (r_wx == r_size - 1'b1) begin
                    r_wx <= '0;
                    r_wy <= r_wy + 1'b1;
                end else begin
                    r_wx <= r_wx + 1'b1;
                end
                if (in_frame && (r_size != '0)) r_cnt <= r_cnt + 1'b1;
            end
            if (r_canvas_vld) begin
                for (int k = 0; k < 3; k++)
                    r_sum[k] <= r_sum[k] + SW'(r_canvas_q[16-8*k +: 8]);
            end
        end
        if (i_cmd.clear_res) begin
            r_red <= 8'd0; r_green <= 8'd0; r_blue <= 8'd0;
        end else if (i_cmd.cap_read) begin
            r_red   <= r_canvas_q[23:16];
            r_green <= r_canvas_q[15:8];
            r_blue  <= r_canvas_q[7:0];
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
endmodule

[rtl/inc_ctrl.sv]
// Controller state machine: sequences load, read and pass requests.
// Depends on inc_pkg; drives inc_datapath through t_cmd.
module inc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  inc_pkg::t_req  i_req,
    output logic           o_req_stall,
    output logic           o_res_valid,
    input  logic           i_res_stall,
    output logic [1:0]     o_done_kind,
    output inc_pkg::t_cmd  o_cmd,
    input  inc_pkg::t_sts  i_sts,
    input  logic           i_idx_ok
);
    import inc_pkg::*;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic [1:0] r_kind;
    logic   r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    logic accept;
    assign accept = i_req_valid && !o_req_stall;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_req;
            r_rd_ok <= i_idx_ok;
        end
    end

    // a result waiting in the output register holds off the next item
    assign o_req_stall = (r_state != ST_IDLE) || r_res_valid;

    always_comb begin
        n_state     = r_state;
        n_res_valid = r_res_valid && i_res_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.clear_res = 1'b1;
                    case (i_req)
                        REQ_LOAD: begin
                            o_cmd.load_wr = 1'b1;
                            n_state = ST_DONE;
                        end
                        REQ_PASS: begin
                            o_cmd.pass_init = 1'b1;
                            n_state = ST_PIX_START;
                        end
                        REQ_READ: begin
                            o_cmd.rd_canvas = 1'b1;
                            n_state = ST_READ_WAIT;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ_WAIT: begin
                o_cmd.cap_read = r_rd_ok;
                n_state = ST_DONE;
            end
            ST_PIX_START: begin
                o_cmd.pix_init = 1'b1;
                n_state = i_sts.frame_empty ? ST_DONE : ST_WIN_ISSUE;
            end
            ST_WIN_ISSUE: begin
                o_cmd.win_step = 1'b1;
                if (i_sts.win_last) n_state = ST_WIN_DRAIN;
            end
            ST_WIN_DRAIN: n_state = ST_ORIG_WAIT;  // last sum lands
            ST_ORIG_WAIT: n_state = ST_WRITE;
            ST_WRITE: begin
                o_cmd.wr_result = 1'b1;
                n_state = i_sts.pix_last ? ST_DONE : ST_NEXT;
            end
            ST_NEXT: begin
                o_cmd.pix_next = 1'b1;
                n_state = ST_PIX_START;
            end
            ST_DONE: begin
                n_res_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_done_kind = r_kind;
endmodule

[rtl/inc_checker.sv]
// Port-level assertions for the neighbor compensation block, bound to the top.
// Depends on inc_pkg and the top level's ports.
module inc_assert (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       o_req_stall,
    input logic [1:0] i_req_type,
    input logic       o_res_valid,
    input logic       i_res_stall,
    input logic [7:0] o_red_out,
    input logic [1:0] o_done_kind
);
    import inc_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_done_kind))
        else $error("result dropped under stall");
    a_no_accept_while_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_req_stall)
        else $error("item accepted while result pending");
    a_load_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall && i_req_type == REQ_LOAD |=> ##1 o_res_valid
        && o_done_kind == REQ_LOAD)
        else $error("load result missing");
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_done_kind != REQ_READ |-> o_red_out == 8'd0)
        else $error("nonzero colour on non-read result");
endmodule

bind inplace_neighbour_compensation inc_assert u_inc_assert (.*);
